>>> design/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Widths, register codes and shared types of the cubic Hermite sampler.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int VB = 32;
  localparam int IB = 16;

  localparam int AW  = VB + IB + 2;
  localparam int BW  = VB + 2 * IB + 3;
  localparam int CW  = VB + 3 * IB;
  localparam int H1W = VB + 2 * IB + 4;
  localparam int H2W = VB + 3 * IB + 5;
  localparam int NW  = VB + 4 * IB + 6;
  localparam int NMW = NW + 1;
  localparam int DW  = 3 * IB;
  localparam int RW  = DW + 1;

  localparam int CFG_IDX_W   = 3;
  localparam int POLY_STAGES = 12;
  localparam int LATENCY     = POLY_STAGES + VB + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_VALUE = 3'd0,
    REG_END_VALUE   = 3'd1,
    REG_START_SLOPE = 3'd2,
    REG_END_SLOPE   = 3'd3,
    REG_SPAN_LENGTH = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic [CW-1:0] c;
    logic [CW-1:0] e;
    logic [DW-1:0] d;
  } coef_t;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [VB-1:0] dvd;
    logic [VB-1:0] quo;
    logic [RW-1:0] den;
  } div_t;

endpackage

>>> design/chs_coef.sv
// ----------------------------------------------------------------------------
// chs_coef
// Configuration registers and the scaled polynomial coefficients.
// ----------------------------------------------------------------------------
module chs_coef import chs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VB-1:0]        cfg_data_i,
  output coef_t                coef_o
);

  logic signed [VB-1:0] y0_q, y1_q, s0_q, s1_q;
  logic [IB-1:0]        n_q;

  logic signed [VB:0]        dif_d, rif_d;
  logic signed [VB:0]        sum_d, sum_q;
  logic signed [VB+1:0]      dif2_d, dif2_q;
  logic signed [VB+2:0]      t3_d, t3_q;
  logic signed [VB+1:0]      u_d, u_q;
  logic signed [VB+IB-1:0]   s0n_d, s0n_q, y0n_d, y0n_q;
  logic [2*IB-1:0]           n2_d, n2_q;
  logic [IB-1:0]             n1_q;

  logic signed [AW-1:0]      a_d, a_q;
  logic signed [VB+IB+2:0]   bt_d, bt_q;
  logic signed [VB+IB+1:0]   un_d, un_q;
  logic signed [VB+2*IB-1:0] s0n2_d, s0n2_q, y0n2_d, y0n2_q;
  logic [DW-1:0]             n3_d, n3_q;

  logic signed [BW-1:0]      b_d, b_q;
  logic signed [CW-1:0]      c_d, c_q, e_d, e_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y0_q <= '0;
      y1_q <= '0;
      s0_q <= '0;
      s1_q <= '0;
      n_q  <= {{(IB-1){1'b0}}, 1'b1};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_START_VALUE: y0_q <= cfg_data_i;
        REG_END_VALUE:   y1_q <= cfg_data_i;
        REG_START_SLOPE: s0_q <= cfg_data_i;
        REG_END_SLOPE:   s1_q <= cfg_data_i;
        REG_SPAN_LENGTH: begin
          // zero span behaves as one
          n_q <= (cfg_data_i[IB-1:0] == '0) ? {{(IB-1){1'b0}}, 1'b1} : cfg_data_i[IB-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    dif_d  = y0_q - y1_q;
    rif_d  = y1_q - y0_q;
    sum_d  = s0_q + s1_q;
    dif2_d = $signed({dif_d, 1'b0});
    t3_d   = $signed({rif_d, 1'b0}) + rif_d;
    u_d    = $signed({s0_q, 1'b0}) + s1_q;
    s0n_d  = s0_q * $signed({1'b0, n_q});
    y0n_d  = y0_q * $signed({1'b0, n_q});
    n2_d   = n_q * n_q;

    a_d    = sum_q * $signed({1'b0, n1_q}) + dif2_q;
    bt_d   = t3_q * $signed({1'b0, n1_q});
    un_d   = u_q * $signed({1'b0, n1_q});
    s0n2_d = s0n_q * $signed({1'b0, n1_q});
    y0n2_d = y0n_q * $signed({1'b0, n1_q});
    n3_d   = n2_q * n1_q;

    b_d    = bt_q - un_q * $signed({1'b0, n1_q});
    c_d    = s0n2_q * $signed({1'b0, n1_q});
    e_d    = y0n2_q * $signed({1'b0, n1_q});
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    dif2_q <= dif2_d;
    t3_q   <= t3_d;
    u_q    <= u_d;
    s0n_q  <= s0n_d;
    y0n_q  <= y0n_d;
    n2_q   <= n2_d;
    n1_q   <= n_q;
    a_q    <= a_d;
    bt_q   <= bt_d;
    un_q   <= un_d;
    s0n2_q <= s0n2_d;
    y0n2_q <= y0n2_d;
    n3_q   <= n3_d;
    b_q    <= b_d;
    c_q    <= c_d;
    e_q    <= e_d;
  end

  assign coef_o.a = a_q;
  assign coef_o.b = b_q;
  assign coef_o.c = c_q;
  assign coef_o.e = e_q;
  assign coef_o.d = n3_q;

endmodule

>>> design/chs_poly.sv
// ----------------------------------------------------------------------------
// chs_poly
// Horner pipeline for the scaled cubic, rounding offset and divider setup.
// ----------------------------------------------------------------------------
module chs_poly import chs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [IB-1:0] sample_index_i,
  input  coef_t         coef_i,
  output div_t          div_o
);

  localparam int AL   = AW / 2;
  localparam int AHW  = AW - AL + IB + 1;
  localparam int ALW  = AL + IB;
  localparam int H1L  = H1W / 2;
  localparam int H1HW = H1W - H1L + IB + 1;
  localparam int H1LW = H1L + IB;
  localparam int H2L  = H2W / 2;
  localparam int H2HW = H2W - H2L + IB + 1;
  localparam int H2LW = H2L + IB;

  logic [POLY_STAGES-1:0] v_q;
  logic [IB-1:0]          idx_q [7];

  logic signed [AHW-1:0]  ahi_d, ahi_q;
  logic [ALW-1:0]         alo_d, alo_q;
  logic signed [H1W-1:0]  t1_hi, t1_lo, t1_b, h1_d, h1_q;
  logic signed [H1HW-1:0] h1hi_d, h1hi_q;
  logic [H1LW-1:0]        h1lo_d, h1lo_q;
  logic signed [H2W-1:0]  t2_hi, t2_lo, t2_c, h2_d, h2_q;
  logic signed [H2HW-1:0] h2hi_d, h2hi_q;
  logic [H2LW-1:0]        h2lo_d, h2lo_q;
  logic signed [NW-1:0]   t3_hi, t3_lo, t3_e, num_d, num_q;
  logic [DW-1:0]          d9_q, d10_q, d11_q;
  logic [NW-1:0]          numu, mag_d, mag_q;
  logic                   neg10_q, neg11_q;
  logic [NMW-1:0]         nm_d, nm_q;
  logic [RW-1:0]          den;
  div_t                   div_d, div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[POLY_STAGES-2:0], accept_i};
    end
  end

  always_comb begin
    ahi_d  = $signed(coef_i.a[AW-1:AL]) * $signed({1'b0, idx_q[2]});
    alo_d  = coef_i.a[AL-1:0] * idx_q[2];

    t1_hi  = ahi_q;
    t1_lo  = alo_q;
    t1_b   = $signed(coef_i.b);
    h1_d   = (t1_hi <<< AL) + t1_lo + t1_b;

    h1hi_d = $signed(h1_q[H1W-1:H1L]) * $signed({1'b0, idx_q[4]});
    h1lo_d = h1_q[H1L-1:0] * idx_q[4];

    t2_hi  = h1hi_q;
    t2_lo  = h1lo_q;
    t2_c   = $signed(coef_i.c);
    h2_d   = (t2_hi <<< H1L) + t2_lo + t2_c;

    h2hi_d = $signed(h2_q[H2W-1:H2L]) * $signed({1'b0, idx_q[6]});
    h2lo_d = h2_q[H2L-1:0] * idx_q[6];

    t3_hi  = h2hi_q;
    t3_lo  = h2lo_q;
    t3_e   = $signed(coef_i.e);
    num_d  = (t3_hi <<< H2L) + t3_lo + t3_e;

    numu   = num_q;
    mag_d  = num_q[NW-1] ? (~numu + NW'(1)) : numu;

    // round half away from zero: (2|num| + D) / 2D
    nm_d   = {mag_q, 1'b0} + NMW'(d10_q);

    den         = {d11_q, 1'b0};
    div_d.valid = v_q[POLY_STAGES-2];
    div_d.neg   = neg11_q;
    div_d.ovf   = nm_q >= (NMW'(den) << VB);
    div_d.rem   = nm_q[VB+RW-1:VB];
    div_d.dvd   = nm_q[VB-1:0];
    div_d.quo   = '0;
    div_d.den   = den;
  end

  always_ff @(posedge clk_i) begin
    idx_q[0] <= sample_index_i;
    for (int k = 1; k < 7; k++) begin
      idx_q[k] <= idx_q[k-1];
    end
    ahi_q   <= ahi_d;
    alo_q   <= alo_d;
    h1_q    <= h1_d;
    h1hi_q  <= h1hi_d;
    h1lo_q  <= h1lo_d;
    h2_q    <= h2_d;
    h2hi_q  <= h2hi_d;
    h2lo_q  <= h2lo_d;
    num_q   <= num_d;
    d9_q    <= coef_i.d;
    mag_q   <= mag_d;
    neg10_q <= num_q[NW-1];
    d10_q   <= d9_q;
    nm_q    <= nm_d;
    neg11_q <= neg10_q;
    d11_q   <= d10_q;
    div_q   <= div_d;
  end

  always_comb begin
    div_o       = div_q;
    div_o.valid = v_q[POLY_STAGES-1];
  end

endmodule

>>> design/chs_div_cell.sv
// ----------------------------------------------------------------------------
// chs_div_cell
// One restoring division step: resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chs_div_cell import chs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t div_i,
  output div_t div_o
);

  logic [RW:0] trial;
  logic        ge;
  div_t        pay_d, pay_q;
  logic        valid_q;

  always_comb begin
    trial     = {div_i.rem, div_i.dvd[VB-1]};
    ge        = trial >= {1'b0, div_i.den};
    pay_d     = div_i;
    pay_d.rem = ge ? RW'(trial - {1'b0, div_i.den}) : trial[RW-1:0];
    pay_d.dvd = {div_i.dvd[VB-2:0], 1'b0};
    pay_d.quo = {div_i.quo[VB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= div_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    div_o       = pay_q;
    div_o.valid = valid_q;
  end

endmodule

>>> design/cubic_hermite_segment_sampler.sv
// ----------------------------------------------------------------------------
// cubic_hermite_segment_sampler
// Structure: 12 poly stages, 32 divider cells (one quotient bit each) and one
// output register lie between the accepting edge and the rise of done_o.
// Throughput: one transaction per cycle; busy_o stays low and results cannot
// be stalled. Reset clears the pipeline valids and sets the registers to zero
// with a span of one.
// ----------------------------------------------------------------------------
module cubic_hermite_segment_sampler import chs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [IB-1:0]        sample_index_i,
  output logic                 done_o,
  output logic signed [VB-1:0] curve_sample_o,
  output logic                 clipped_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VB-1:0]        cfg_data_i
);

  coef_t         coef;
  div_t          chain [VB+1];
  div_t          tail;
  logic [VB-1:0] lim, mag, res_d;
  logic          clip_d;
  logic          done_q, clip_q;
  logic [VB-1:0] res_q;

  assign busy_o = 1'b0;

  chs_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  chs_poly u_poly (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (start_i && !busy_o),
    .sample_index_i (sample_index_i),
    .coef_i         (coef),
    .div_o          (chain[0])
  );

  for (genvar k = 0; k < VB; k++) begin : g_cell
    chs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .div_i  (chain[k]),
      .div_o  (chain[k+1])
    );
  end

  assign tail = chain[VB];

  always_comb begin
    lim    = tail.neg ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    clip_d = tail.ovf || (tail.quo > lim);
    mag    = clip_d ? lim : tail.quo;
    res_d  = tail.neg ? (~mag + VB'(1)) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    clip_q <= clip_d;
  end

  assign done_o         = done_q;
  assign curve_sample_o = res_q;
  assign clipped_o      = clip_q;

endmodule

>>> design/chs_sva.sv
// ----------------------------------------------------------------------------
// chs_sva
// Port-level checks of result timing and saturation codes.
// ----------------------------------------------------------------------------
module chs_sva import chs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic [IB-1:0]        sample_index_i,
  input logic                 done_o,
  input logic signed [VB-1:0] curve_sample_o,
  input logic                 clipped_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [VB-1:0]        cfg_data_i
);

  localparam logic [VB-1:0] MAX_CODE = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] MIN_CODE = {1'b1, {(VB-1){1'b0}}};

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("transaction produced no result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching transaction");

  a_clip_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && clipped_o |-> (curve_sample_o == MAX_CODE) || (curve_sample_o == MIN_CODE))
    else $error("clipped result is not a saturation code");

endmodule

bind cubic_hermite_segment_sampler chs_sva u_chs_sva (.*);
